/* rtl/core/msfb_pkg.sv */
`default_nettype none

package msfb_pkg;

  // Field widths.
  localparam int unsigned HZ_W     = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values and fixed frame contents.
  localparam logic [BYTE_W-1:0] NODE_ADDRESS_RESET    = 8'h01;
  localparam logic [WORD_W-1:0] TARGET_REGISTER_RESET = 16'h02AB;
  localparam logic [BYTE_W-1:0] FUNC_WRITE_SINGLE     = 8'h06;

  // CRC-16/MODBUS.
  localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;
  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;

  // Speed scale 136.533 held as the exact ratio 136533/1000, rounded half up.
  localparam int unsigned SCALE_NUM  = 136533;
  localparam int unsigned SCALE_DEN  = 1000;
  localparam int unsigned SCALE_HALF = 500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_ADDRESS    = 2'd0,
    CFG_TARGET_REGISTER = 2'd1
  } cfg_index_t;

  // Position of a byte within the eight-byte frame, in transmit order.
  typedef enum logic [2:0] {
    POS_NODE,
    POS_FUNC,
    POS_REG_HI,
    POS_REG_LO,
    POS_SPD_HI,
    POS_SPD_LO,
    POS_CRC_LO,
    POS_CRC_HI
  } byte_pos_t;

  // Everything the serialiser needs to build one frame.
  typedef struct packed {
    logic [BYTE_W-1:0] node_address;
    logic [WORD_W-1:0] target_register;
    logic [WORD_W-1:0] speed;
  } msfb_frame_t;

  typedef logic [2**HZ_W-1:0][WORD_W-1:0] speed_lut_t;

  // Built at elaboration: one speed value for every possible frequency.
  function automatic speed_lut_t build_speed_lut();
    speed_lut_t  lut;
    int unsigned v;
    for (int h = 0; h < 2**HZ_W; h++) begin
      v = (h * SCALE_NUM + SCALE_HALF) / SCALE_DEN;
      lut[h] = WORD_W'(v);
    end
    return lut;
  endfunction

  localparam speed_lut_t SPEED_LUT = build_speed_lut();

  // Folds one byte into the running CRC, least significant bit first.
  function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] c;
    c = crc_in ^ {{(WORD_W-BYTE_W){1'b0}}, data};
    for (int b = 0; b < BYTE_W; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/msfb_if.sv */
`default_nettype none

interface msfb_req_if;
  logic                      valid;
  logic                      ready;
  logic [msfb_pkg::HZ_W-1:0] frequency_hz;

  modport source (output valid, output frequency_hz, input ready);
  modport sink   (input valid, input frequency_hz, output ready);
endinterface

interface msfb_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [msfb_pkg::BYTE_W-1:0] frame_byte;
  logic                        last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface msfb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [msfb_pkg::CFG_IDX_W-1:0] index;
  logic [msfb_pkg::WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/msfb_frame_ser.sv */
`default_nettype none

module msfb_frame_ser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load_valid,
  input  wire msfb_pkg::msfb_frame_t load_frame,
  output logic                       load_ready,
  msfb_rsp_if.source                 rsp
);
  import msfb_pkg::*;

  logic              busy;
  byte_pos_t         pos;
  logic [WORD_W-1:0] crc;
  msfb_frame_t       frame_q;
  logic              out_v;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  logic              out_adv;
  logic              emit;
  logic              at_end;
  logic              load;
  logic [BYTE_W-1:0] cur_byte;
  logic              crc_en;

  assign out_adv    = !out_v || rsp.ready;
  assign emit       = busy && out_adv;
  assign at_end     = (pos == POS_CRC_HI);
  assign load_ready = !busy || (emit && at_end);
  assign load       = load_valid && load_ready;

  always_comb begin
    crc_en = 1'b1;
    unique case (pos)
      POS_NODE:   cur_byte = frame_q.node_address;
      POS_FUNC:   cur_byte = FUNC_WRITE_SINGLE;
      POS_REG_HI: cur_byte = frame_q.target_register[WORD_W-1:BYTE_W];
      POS_REG_LO: cur_byte = frame_q.target_register[BYTE_W-1:0];
      POS_SPD_HI: cur_byte = frame_q.speed[WORD_W-1:BYTE_W];
      POS_SPD_LO: cur_byte = frame_q.speed[BYTE_W-1:0];
      POS_CRC_LO: begin
        cur_byte = crc[BYTE_W-1:0];
        crc_en   = 1'b0;
      end
      POS_CRC_HI: begin
        cur_byte = crc[WORD_W-1:BYTE_W];
        crc_en   = 1'b0;
      end
      default: begin
        cur_byte = '0;
        crc_en   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pos   <= POS_NODE;
      out_v <= 1'b0;
    end else begin
      if (out_adv) begin
        out_v <= busy;
      end
      if (load) begin
        busy <= 1'b1;
        pos  <= POS_NODE;
      end else if (emit) begin
        if (at_end) begin
          busy <= 1'b0;
        end
        pos <= byte_pos_t'(pos + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_q <= load_frame;
      crc     <= CRC_INIT;
    end else if (emit && crc_en) begin
      crc <= crc16_byte(crc, cur_byte);
    end
    if (emit) begin
      out_byte <= cur_byte;
      out_last <= at_end;
    end
  end

  assign rsp.valid      = out_v;
  assign rsp.frame_byte = out_byte;
  assign rsp.last_byte  = out_last;

endmodule

`default_nettype wire

/* rtl/core/modbus_speed_frame_builder_core.sv */
// The first frame byte is offered once its item has passed the input register and the
// serialiser's frame register, when the output side is free; the byte serialiser then
// hands out the remaining seven bytes one per cycle through its output register while
// rsp.ready holds. A new item can be taken while earlier frame bytes are still going out.
// Reset (rst, synchronous, active high) empties the input and output registers and
// sets node_address to 1 and target_register to 683.
`default_nettype none

module modbus_speed_frame_builder_core (
  input  wire logic clk,
  input  wire logic rst,
  msfb_cfg_if.sink  cfg,
  msfb_req_if.sink  req,
  msfb_rsp_if.source rsp
);
  import msfb_pkg::*;

  // Configuration registers. The user must write these only while the block is idle;
  // the block does not enforce this. Writes are always accepted; other indices are ignored.
  logic [BYTE_W-1:0] node_address;
  logic [WORD_W-1:0] target_register;

  // Input register: holds one frequency item while the serialiser finishes the
  // previous frame, so a new item can be taken while earlier bytes are still going out.
  logic              hz_v;
  logic [HZ_W-1:0]   hz_q;

  logic              load_ready;
  msfb_frame_t       frame;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address    <= NODE_ADDRESS_RESET;
      target_register <= TARGET_REGISTER_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_NODE_ADDRESS) begin
        node_address <= cfg.data[BYTE_W-1:0];
      end else if (cfg.index == CFG_TARGET_REGISTER) begin
        target_register <= cfg.data;
      end
    end
  end

  // The input register is free when empty, or when its item moves into the
  // serialiser in this very cycle.
  assign req.ready = !hz_v || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hz_v <= 1'b0;
    end else if (req.ready) begin
      hz_v <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      hz_q <= req.frequency_hz;
    end
  end

  // The speed value comes from a constant table built at elaboration: the frequency
  // is only eight bits wide, so this replaces the multiply and the divide by 1000.
  always_comb begin
    frame.node_address    = node_address;
    frame.target_register = target_register;
    frame.speed           = SPEED_LUT[hz_q];
  end

  // The serialiser snapshots the frame fields, emits the six message bytes while
  // folding each into the CRC, then emits the CRC low and high bytes.
  msfb_frame_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load_valid (hz_v),
    .load_frame (frame),
    .load_ready (load_ready),
    .rsp        (rsp)
  );

  // An item that cannot yet enter the serialiser stays put in the input register.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    hz_v && !load_ready |=> hz_v && $stable(hz_q))
    else $error("input item lost or changed while waiting for the serialiser");

  // Frames are eight bytes long, so two final bytes can never follow each other.
  a_last_spacing: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready && rsp.last_byte |=> !(rsp.valid && rsp.last_byte))
    else $error("final frame byte repeated");

  // A node address write lands in the register.
  a_cfg_node: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.index == CFG_NODE_ADDRESS |=> node_address == $past(cfg.data[BYTE_W-1:0]))
    else $error("node address write not taken");

endmodule

`default_nettype wire
